[rtl/srrc_pkg.sv]
// Shared constants and the squared-sine threshold table of the stick range calibrator.
package srrc_pkg;

  // Angle resolution of the per-stick maximum table.
  localparam int ANGLE_BUCKETS = 360;
  localparam int TBL_DEPTH     = 2 * ANGLE_BUCKETS;
  localparam int TBL_AW        = $clog2(TBL_DEPTH);
  localparam int BKT_W         = $clog2(ANGLE_BUCKETS);

  // Bucket = deg * ANGLE_BUCKETS / 360, done as a multiply by a rounded-up reciprocal.
  localparam int NUM_W     = 9 + BKT_W;
  localparam int DIV_SHIFT = NUM_W + 9;
  localparam logic [NUM_W:0] RECIP =
    (NUM_W + 1)'(((64'd1 << DIV_SHIFT) + 64'd359) / 64'd360);

  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [16:0] MAG_LIMIT  = 17'd32767;
  localparam logic [29:0] DEC9       = 30'd1000000000;
  localparam logic [63:0] E9         = 64'd1000000000;

  localparam logic [8:0] DEG_HALF = 9'd180;
  localparam logic [8:0] DEG_FULL = 9'd360;
  localparam logic [8:0] DEG_LAST = 9'd359;
  localparam logic [6:0] ANG_MAX  = 7'd90;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT_X  = 2'd0;
  localparam logic [1:0] REG_LEFT_Y  = 2'd1;
  localparam logic [1:0] REG_RIGHT_X = 2'd2;
  localparam logic [1:0] REG_RIGHT_Y = 2'd3;

  // floor(sin(d)^2 * 1e9) with sin rounded to 1e-9, for d = 0..90 degrees.
  localparam logic [29:0] SQ9 [0:90] = '{
    30'd0,
    30'(64'd17452406 * 64'd17452406 / E9), 30'(64'd34899497 * 64'd34899497 / E9),
    30'(64'd52335956 * 64'd52335956 / E9), 30'(64'd69756474 * 64'd69756474 / E9),
    30'(64'd87155743 * 64'd87155743 / E9), 30'(64'd104528463 * 64'd104528463 / E9),
    30'(64'd121869343 * 64'd121869343 / E9), 30'(64'd139173101 * 64'd139173101 / E9),
    30'(64'd156434465 * 64'd156434465 / E9), 30'(64'd173648178 * 64'd173648178 / E9),
    30'(64'd190808995 * 64'd190808995 / E9), 30'(64'd207911691 * 64'd207911691 / E9),
    30'(64'd224951054 * 64'd224951054 / E9), 30'(64'd241921896 * 64'd241921896 / E9),
    30'(64'd258819045 * 64'd258819045 / E9), 30'(64'd275637356 * 64'd275637356 / E9),
    30'(64'd292371705 * 64'd292371705 / E9), 30'(64'd309016994 * 64'd309016994 / E9),
    30'(64'd325568154 * 64'd325568154 / E9), 30'(64'd342020143 * 64'd342020143 / E9),
    30'(64'd358367950 * 64'd358367950 / E9), 30'(64'd374606593 * 64'd374606593 / E9),
    30'(64'd390731128 * 64'd390731128 / E9), 30'(64'd406736643 * 64'd406736643 / E9),
    30'(64'd422618262 * 64'd422618262 / E9), 30'(64'd438371147 * 64'd438371147 / E9),
    30'(64'd453990500 * 64'd453990500 / E9), 30'(64'd469471563 * 64'd469471563 / E9),
    30'(64'd484809620 * 64'd484809620 / E9), 30'(64'd500000000 * 64'd500000000 / E9),
    30'(64'd515038075 * 64'd515038075 / E9), 30'(64'd529919264 * 64'd529919264 / E9),
    30'(64'd544639035 * 64'd544639035 / E9), 30'(64'd559192903 * 64'd559192903 / E9),
    30'(64'd573576436 * 64'd573576436 / E9), 30'(64'd587785252 * 64'd587785252 / E9),
    30'(64'd601815023 * 64'd601815023 / E9), 30'(64'd615661475 * 64'd615661475 / E9),
    30'(64'd629320391 * 64'd629320391 / E9), 30'(64'd642787610 * 64'd642787610 / E9),
    30'(64'd656059029 * 64'd656059029 / E9), 30'(64'd669130606 * 64'd669130606 / E9),
    30'(64'd681998360 * 64'd681998360 / E9), 30'(64'd694658370 * 64'd694658370 / E9),
    30'(64'd707106781 * 64'd707106781 / E9), 30'(64'd719339800 * 64'd719339800 / E9),
    30'(64'd731353702 * 64'd731353702 / E9), 30'(64'd743144825 * 64'd743144825 / E9),
    30'(64'd754709580 * 64'd754709580 / E9), 30'(64'd766044443 * 64'd766044443 / E9),
    30'(64'd777145961 * 64'd777145961 / E9), 30'(64'd788010754 * 64'd788010754 / E9),
    30'(64'd798635510 * 64'd798635510 / E9), 30'(64'd809016994 * 64'd809016994 / E9),
    30'(64'd819152044 * 64'd819152044 / E9), 30'(64'd829037573 * 64'd829037573 / E9),
    30'(64'd838670568 * 64'd838670568 / E9), 30'(64'd848048096 * 64'd848048096 / E9),
    30'(64'd857167301 * 64'd857167301 / E9), 30'(64'd866025404 * 64'd866025404 / E9),
    30'(64'd874619707 * 64'd874619707 / E9), 30'(64'd882947593 * 64'd882947593 / E9),
    30'(64'd891006524 * 64'd891006524 / E9), 30'(64'd898794046 * 64'd898794046 / E9),
    30'(64'd906307787 * 64'd906307787 / E9), 30'(64'd913545458 * 64'd913545458 / E9),
    30'(64'd920504853 * 64'd920504853 / E9), 30'(64'd927183855 * 64'd927183855 / E9),
    30'(64'd933580426 * 64'd933580426 / E9), 30'(64'd939692621 * 64'd939692621 / E9),
    30'(64'd945518576 * 64'd945518576 / E9), 30'(64'd951056516 * 64'd951056516 / E9),
    30'(64'd956304756 * 64'd956304756 / E9), 30'(64'd961261696 * 64'd961261696 / E9),
    30'(64'd965925826 * 64'd965925826 / E9), 30'(64'd970295726 * 64'd970295726 / E9),
    30'(64'd974370065 * 64'd974370065 / E9), 30'(64'd978147601 * 64'd978147601 / E9),
    30'(64'd981627183 * 64'd981627183 / E9), 30'(64'd984807753 * 64'd984807753 / E9),
    30'(64'd987688341 * 64'd987688341 / E9), 30'(64'd990268069 * 64'd990268069 / E9),
    30'(64'd992546152 * 64'd992546152 / E9), 30'(64'd994521895 * 64'd994521895 / E9),
    30'(64'd996194698 * 64'd996194698 / E9), 30'(64'd997564050 * 64'd997564050 / E9),
    30'(64'd998629535 * 64'd998629535 / E9), 30'(64'd999390827 * 64'd999390827 / E9),
    30'(64'd999847695 * 64'd999847695 / E9), 30'(64'd1000000000 * 64'd1000000000 / E9)
  };

endpackage

[rtl/stick_radial_range_calibrator.sv]
// Top level of the two-stick radial range calibrator.
//
// The input channel (in_valid/in_ready) carries one word per axis sample: stick, axis and
// the raw value. Every accepted word yields exactly one word on the output channel
// (out_valid/out_ready): the calibrated position of the axis that moved.
// The configuration channel (cfg_valid/cfg_ready) writes the four center registers by
// index; it is always ready, and a write also sets that axis's last position.
// One word is worked on at a time. A word with a nonzero offset passes, between
// acceptance and the output register, through the shared restoring square
// root (17 and 15 steps), the shared restoring divider (15 and 30 steps) and the
// seven-step angle search, which uses the 33x18 multiplier on each step.
// A word whose offset is zero skips these units. A new word can be accepted in the
// cycle after the result is loaded, even while that result still waits for the
// receiver, unless a configuration write is offered then. If the receiver stalls,
// the next result waits in the output state until the register frees.
// After reset the per-bucket maximum memory is cleared, one entry a cycle; no word is
// accepted meanwhile, while configuration writes are taken.
// Centers reset to zero, and so do the last positions through their valid bits.
module stick_radial_range_calibrator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               stick,
  input  logic               axis,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] calibrated_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // The sequencer steps through one word's work; each state is one step of that work or
  // one step of an iterative unit.
  typedef enum logic [23:0] {
    ST_CLEAR = 24'h000001,
    ST_IDLE  = 24'h000002,
    ST_LOAD  = 24'h000004,
    ST_SQW   = 24'h000008,
    ST_SQH   = 24'h000010,
    ST_SUM   = 24'h000020,
    ST_SQRT  = 24'h000040,
    ST_PRE0  = 24'h000080,
    ST_PRE1  = 24'h000100,
    ST_PRE2  = 24'h000200,
    ST_ANG0  = 24'h000400,
    ST_ANG1  = 24'h000800,
    ST_ANG2  = 24'h001000,
    ST_BKT0  = 24'h002000,
    ST_BKT1  = 24'h004000,
    ST_TRD   = 24'h008000,
    ST_TBL   = 24'h010000,
    ST_DIV   = 24'h020000,
    ST_AA    = 24'h040000,
    ST_AAL   = 24'h080000,
    ST_LIM0  = 24'h100000,
    ST_LIM1  = 24'h200000,
    ST_LIM2  = 24'h400000,
    ST_OUT   = 24'h800000
  } state_t;

  // Which use of a shared iterative unit is running.
  typedef enum logic {
    PASS_FIRST  = 1'b0,
    PASS_SECOND = 1'b1
  } pass_t;

  state_t state;

  // Center registers.
  logic signed [15:0] center_lx, center_ly, center_rx, center_ry;

  // Last positions: one small memory per axis, addressed by stick, with valid bits so
  // that an entry never written reads as zero.
  logic [15:0] pos_x_mem [2];
  logic [15:0] pos_y_mem [2];
  logic [1:0]  pos_x_vld, pos_y_vld;
  logic [15:0] pos_x_q, pos_y_q;

  // Per-bucket maximum magnitude memory.
  logic [16:0]                 tbl_mem [srrc_pkg::TBL_DEPTH];
  logic [16:0]                 tbl_q;
  logic [srrc_pkg::TBL_AW-1:0] tbl_addr, clr_cnt, tbl_wa;
  logic [16:0]                 tbl_wd;
  logic                        tbl_we, tbl_upd;
  logic [16:0]                 mx_w;

  // Word being worked on.
  logic                       stick_r, axis_r;
  logic signed [15:0]         value_r;
  logic                       w_neg, h_neg;
  logic [15:0]                aw, ah;
  logic [31:0]                ww, hh;
  logic [32:0]                s_r;
  logic [16:0]                mag_r;
  logic [14:0]                sat_r;
  logic [62:0]                hh9;
  logic [6:0]                 ang_r, ang_bit, ang_cand, ang_idx;
  logic [8:0]                 deg_w;
  logic [srrc_pkg::NUM_W-1:0] num_r;
  logic [2*srrc_pkg::NUM_W:0] bkt_prod;
  logic [14:0]                a_r;
  logic [29:0]                aa_r;
  logic signed [15:0]         res_r;

  // Shared multiplier and the two-part accumulate for the wide products.
  logic [32:0] mul_a;
  logic [17:0] mul_b;
  logic [50:0] prod, part;
  logic [62:0] wide_sum;

  // Restoring divider.
  logic [62:0] dv_rem, dv_den;
  logic [29:0] dv_quo, dv_quo_next;
  logic [4:0]  dv_cnt;
  pass_t       dv_pass;
  logic        dv_ge;

  // Restoring square root.
  logic [33:0] sq_rem, sq_root, sq_bit, sq_try, sq_root_next;
  pass_t       sq_pass;
  logic        sq_ge;

  // Offsets of the current word from its centers.
  logic signed [15:0] x_cur, y_cur, cx, cy;
  logic signed [16:0] w_off, h_off;

  logic in_take, cfg_take, out_load;
  logic [14:0] q_w;
  logic        neg_w;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid;
  // A configuration write and a sample never land in the same cycle, so the position
  // memories need only one write port.
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign in_take   = in_valid && in_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  // Current position: the moved axis takes the new sample, the other one its memory.
  always_comb begin
    x_cur = axis_r ? (pos_x_vld[stick_r] ? pos_x_q : 16'sd0) : value_r;
    y_cur = axis_r ? value_r : (pos_y_vld[stick_r] ? pos_y_q : 16'sd0);
    cx    = stick_r ? center_rx : center_lx;
    cy    = stick_r ? center_ry : center_ly;
    w_off = 17'(x_cur) - 17'(cx);
    h_off = 17'(y_cur) - 17'(cy);
  end

  // Operand selection for the shared multiplier. Wide products are split on the
  // second operand into an 18-bit low part and a 12-bit high part.
  always_comb begin
    ang_cand = ang_r | ang_bit;
    ang_idx  = (ang_cand > srrc_pkg::ANG_MAX) ? srrc_pkg::ANG_MAX : ang_cand;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      ST_SQW: begin
        mul_a = 33'(aw);
        mul_b = 18'(aw);
      end
      ST_SQH: begin
        mul_a = 33'(ah);
        mul_b = 18'(ah);
      end
      ST_PRE0: begin
        mul_a = 33'(hh);
        mul_b = srrc_pkg::DEC9[17:0];
      end
      ST_PRE1: begin
        mul_a = 33'(hh);
        mul_b = 18'(srrc_pkg::DEC9[29:18]);
      end
      ST_ANG0: begin
        mul_a = s_r;
        mul_b = srrc_pkg::SQ9[ang_idx][17:0];
      end
      ST_ANG1: begin
        mul_a = s_r;
        mul_b = 18'(srrc_pkg::SQ9[ang_idx][29:18]);
      end
      ST_AA: begin
        mul_a = 33'(a_r);
        mul_b = 18'(a_r);
      end
      ST_LIM0: begin
        mul_a = axis_r ? 33'(hh) : 33'(ww);
        mul_b = aa_r[17:0];
      end
      ST_LIM1: begin
        mul_a = axis_r ? 33'(hh) : 33'(ww);
        mul_b = 18'(aa_r[29:18]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 51'(mul_a) * 51'(mul_b);
  end

  assign wide_sum = 63'(part) + {prod[44:0], 18'b0};

  // Angle in the full circle from the base angle and the quadrant; a full turn folds
  // onto the last degree.
  always_comb begin
    if (w_neg) begin
      deg_w = h_neg ? (srrc_pkg::DEG_HALF + 9'(ang_r)) : (srrc_pkg::DEG_HALF - 9'(ang_r));
    end else if (h_neg) begin
      deg_w = srrc_pkg::DEG_FULL - 9'(ang_r);
    end else begin
      deg_w = 9'(ang_r);
    end
    if (deg_w == srrc_pkg::DEG_FULL) begin
      deg_w = srrc_pkg::DEG_LAST;
    end
  end

  assign bkt_prod = {{(srrc_pkg::NUM_W + 1){1'b0}}, num_r}
                    * {{srrc_pkg::NUM_W{1'b0}}, srrc_pkg::RECIP};

  // Table update: a larger saturated magnitude stores the raw magnitude.
  assign tbl_upd = {2'b0, sat_r} > tbl_q;
  assign mx_w    = tbl_upd ? mag_r : tbl_q;

  // Divider and square root steps.
  assign dv_ge        = dv_rem >= dv_den;
  assign dv_quo_next  = {dv_quo[28:0], dv_ge};
  assign sq_try       = sq_root + sq_bit;
  assign sq_ge        = sq_rem >= sq_try;
  assign sq_root_next = sq_ge ? ((sq_root >> 1) + sq_bit) : (sq_root >> 1);

  assign q_w   = sq_root_next[14:0];
  assign neg_w = axis_r ? h_neg : w_neg;

  // Position memories: written by samples and by center writes, read at acceptance.
  always_ff @(posedge clk) begin
    if (in_take && !axis) begin
      pos_x_mem[stick] <= value;
    end else if (cfg_take && !cfg_index[0]) begin
      pos_x_mem[cfg_index[1]] <= cfg_data;
    end
    if (in_take && axis) begin
      pos_y_mem[stick] <= value;
    end else if (cfg_take && cfg_index[0]) begin
      pos_y_mem[cfg_index[1]] <= cfg_data;
    end
    if (in_take) begin
      pos_x_q <= pos_x_mem[stick];
      pos_y_q <= pos_y_mem[stick];
    end
  end

  // Maximum table: cleared after reset, then read once per word with a nonzero offset
  // and written back when its magnitude is larger. The write back of one word ends long
  // before the next word's read, so no forwarding is needed.
  assign tbl_we = (state == ST_CLEAR) || ((state == ST_TBL) && tbl_upd);
  assign tbl_wa = (state == ST_CLEAR) ? clr_cnt : tbl_addr;
  assign tbl_wd = (state == ST_CLEAR) ? 17'd0 : mag_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (state == ST_TRD) begin
      tbl_q <= tbl_mem[tbl_addr];
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      center_lx <= '0;
      center_ly <= '0;
      center_rx <= '0;
      center_ry <= '0;
      pos_x_vld <= '0;
      pos_y_vld <= '0;
    end else begin
      if (cfg_take) begin
        case (cfg_index)
          srrc_pkg::REG_LEFT_X: center_lx <= cfg_data;
          srrc_pkg::REG_LEFT_Y: center_ly <= cfg_data;
          srrc_pkg::REG_RIGHT_X: center_rx <= cfg_data;
          srrc_pkg::REG_RIGHT_Y: center_ry <= cfg_data;
          default: center_lx <= center_lx;
        endcase
        if (cfg_index[0]) begin
          pos_y_vld[cfg_index[1]] <= 1'b1;
        end else begin
          pos_x_vld[cfg_index[1]] <= 1'b1;
        end
      end
      if (in_take) begin
        if (axis) begin
          pos_y_vld[stick] <= 1'b1;
        end else begin
          pos_x_vld[stick] <= 1'b1;
        end
      end

      case (state)
        ST_CLEAR: begin
          if (clr_cnt == srrc_pkg::TBL_AW'(srrc_pkg::TBL_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            stick_r <= stick;
            axis_r  <= axis;
            value_r <= value;
            state   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          w_neg <= w_off[16];
          h_neg <= h_off[16];
          aw    <= w_off[16] ? 16'(-w_off) : w_off[15:0];
          ah    <= h_off[16] ? 16'(-h_off) : h_off[15:0];
          if (w_off == 17'sd0 && h_off == 17'sd0) begin
            res_r <= 16'sd0;
            state <= ST_OUT;
          end else begin
            state <= ST_SQW;
          end
        end
        ST_SQW: state <= ST_SQH;
        ST_SQH: begin
          ww    <= prod[31:0];
          state <= ST_SUM;
        end
        ST_SUM: begin
          hh      <= prod[31:0];
          s_r     <= 33'(ww) + 33'(prod[31:0]);
          sq_rem  <= 34'(ww) + 34'(prod[31:0]);
          sq_root <= '0;
          sq_bit  <= 34'd1 << 32;
          sq_pass <= PASS_FIRST;
          state   <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sq_rem <= sq_rem - sq_try;
          end
          sq_root <= sq_root_next;
          sq_bit  <= sq_bit >> 2;
          if (sq_bit == 34'd1) begin
            if (sq_pass == PASS_FIRST) begin
              mag_r <= sq_root_next[16:0];
              state <= ST_PRE0;
            end else begin
              res_r <= neg_w ? 16'(-{1'b0, q_w}) : {1'b0, q_w};
              state <= ST_OUT;
            end
          end
        end
        ST_PRE0: begin
          sat_r <= (mag_r > srrc_pkg::MAG_LIMIT) ? srrc_pkg::FULL_SCALE : mag_r[14:0];
          state <= ST_PRE1;
        end
        ST_PRE1: begin
          part  <= prod;
          state <= ST_PRE2;
        end
        ST_PRE2: begin
          hh9     <= wide_sum;
          ang_r   <= '0;
          ang_bit <= 7'd64;
          state   <= ST_ANG0;
        end
        ST_ANG0: state <= ST_ANG1;
        ST_ANG1: begin
          part  <= prod;
          state <= ST_ANG2;
        end
        ST_ANG2: begin
          // Largest angle whose squared sine still fits under h*h/S.
          if (ang_cand <= srrc_pkg::ANG_MAX && hh9 >= wide_sum) begin
            ang_r <= ang_cand;
          end
          ang_bit <= ang_bit >> 1;
          state   <= (ang_bit == 7'd1) ? ST_BKT0 : ST_ANG0;
        end
        ST_BKT0: begin
          num_r <= srrc_pkg::NUM_W'(deg_w * srrc_pkg::ANGLE_BUCKETS);
          state <= ST_BKT1;
        end
        ST_BKT1: begin
          tbl_addr <= (stick_r ? srrc_pkg::TBL_AW'(srrc_pkg::ANGLE_BUCKETS) : '0)
                      + srrc_pkg::TBL_AW'(bkt_prod[srrc_pkg::DIV_SHIFT +: srrc_pkg::BKT_W]);
          state    <= ST_TRD;
        end
        ST_TRD: state <= ST_TBL;
        ST_TBL: begin
          if (mx_w == 17'd0) begin
            a_r   <= '0;
            state <= ST_AA;
          end else begin
            dv_rem  <= 63'({sat_r, 15'b0} - 30'(sat_r));
            dv_den  <= 63'(mx_w) << 14;
            dv_quo  <= '0;
            dv_cnt  <= 5'd14;
            dv_pass <= PASS_FIRST;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dv_ge) begin
            dv_rem <= dv_rem - dv_den;
          end
          dv_den <= dv_den >> 1;
          dv_quo <= dv_quo_next;
          dv_cnt <= dv_cnt - 1'b1;
          if (dv_cnt == 5'd0) begin
            if (dv_pass == PASS_FIRST) begin
              a_r   <= dv_quo_next[14:0];
              state <= ST_AA;
            end else begin
              // The projection is the root of floor(n*n*A*A / S).
              sq_rem  <= 34'(dv_quo_next);
              sq_root <= '0;
              sq_bit  <= 34'd1 << 28;
              sq_pass <= PASS_SECOND;
              state   <= ST_SQRT;
            end
          end
        end
        ST_AA: state <= ST_AAL;
        ST_AAL: begin
          aa_r  <= prod[29:0];
          state <= ST_LIM0;
        end
        ST_LIM0: state <= ST_LIM1;
        ST_LIM1: begin
          part  <= prod;
          state <= ST_LIM2;
        end
        ST_LIM2: begin
          dv_rem  <= wide_sum;
          dv_den  <= 63'(s_r) << 29;
          dv_quo  <= '0;
          dv_cnt  <= 5'd29;
          dv_pass <= PASS_SECOND;
          state   <= ST_DIV;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      calibrated_value <= res_r;
    end
  end

`ifndef SYNTHESIS
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_LOAD))
    else $error("accepted word did not start loading");

  a_mag_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT && sq_bit == 34'd1 && sq_pass == PASS_FIRST)
    |=> (34'(mag_r) * 34'(mag_r) <= 34'(s_r)))
    else $error("magnitude exceeds the root of the squared offset");

  a_tbl_max: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TBL) |-> (mx_w >= {2'b0, sat_r}))
    else $error("bucket maximum below the current magnitude");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BKT0) |-> (ang_r <= srrc_pkg::ANG_MAX))
    else $error("base angle beyond a quarter turn");
`endif

endmodule
